// ===== design/svb_pkg.sv =====
// Shared constants and types of the straight-alpha source-over blend block.
package svb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CH_NUM        = 3;
  localparam int QUO_BITS      = 9;
  localparam logic [7:0] PIX_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_coverage;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
    logic       bypass;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== design/svb_if.sv =====
// Stream interfaces for pixel requests and blended results.
interface svb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_coverage;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_coverage,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_coverage,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface svb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

// ===== design/svb_front.sv =====
// Front stage: registers incoming pixel requests and marks zero-coverage bypass.
module svb_front (
  input  logic          clk,
  input  logic          rst_n,
  svb_in_if.sink        in_ch,
  output logic          push_valid,
  output svb_pkg::item_t push_item,
  input  logic          push_ready
);
  import svb_pkg::*;

  logic  fr_v_r;
  item_t fr_item_r;
  item_t fr_item_nxt;
  logic  take;

  assign in_ch.ready = !fr_v_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    fr_item_nxt.src_red      = in_ch.src_red;
    fr_item_nxt.src_green    = in_ch.src_green;
    fr_item_nxt.src_blue     = in_ch.src_blue;
    fr_item_nxt.src_coverage = in_ch.src_coverage;
    fr_item_nxt.dst_red      = in_ch.dst_red;
    fr_item_nxt.dst_green    = in_ch.dst_green;
    fr_item_nxt.dst_blue     = in_ch.dst_blue;
    fr_item_nxt.dst_alpha    = in_ch.dst_alpha;
    fr_item_nxt.bypass       = (in_ch.src_coverage == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      fr_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= fr_item_nxt;
    end
  end

  assign push_valid = fr_v_r;
  assign push_item  = fr_item_r;

endmodule

// ===== design/svb_queue.sv =====
// Short request queue between the front stage and the blend pipeline.
module svb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  svb_pkg::item_t  push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output svb_pkg::item_t  pop_item,
  input  logic            pop_ready,
  output svb_pkg::qstat_t stat
);
  import svb_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          full;
  logic          empty;
  logic          push;
  logic          pop;

  assign full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign push  = push_valid && !full;
  assign pop   = pop_ready && !empty;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.full  = full;
  assign stat.empty = empty;

endmodule

// ===== design/svb_back.sv =====
// Blend pipeline: fixed-point weights, products and a pipelined quotient per channel.
module svb_back #(
  parameter int FracBits = svb_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  svb_pkg::item_t q_item,
  output logic           q_ready,
  svb_out_if.source      out_ch
);
  import svb_pkg::*;

  localparam int FW = FracBits + 1;
  localparam int PW = 2 * FW;
  localparam int RW = PW + 8;
  localparam logic [FW-1:0] ONE = FW'(1) << FracBits;

  logic [FW-1:0] frac_lut [256];

  for (genvar g = 0; g < 256; g++) begin : g_lut
    localparam logic [63:0] LV = (64'(g) << FracBits) / 64'd255;
    assign frac_lut[g] = FW'(LV);
  end

  logic adv;

  logic [7:0] in_sc [CH_NUM];
  logic [7:0] in_dc [CH_NUM];

  logic          s0_v_r;
  logic [FW-1:0] s0_fs_r [CH_NUM];
  logic [FW-1:0] s0_fd_r [CH_NUM];
  logic [FW-1:0] s0_sa_r;
  logic [FW-1:0] s0_da_r;
  logic [FW-1:0] s0_inv_r;
  logic [7:0]    s0_dc_r [CH_NUM];
  logic [7:0]    s0_dal_r;
  logic          s0_byp_r;

  logic [PW-1:0] wd_prod;
  logic          s1_v_r;
  logic [FW-1:0] s1_fs_r [CH_NUM];
  logic [FW-1:0] s1_fd_r [CH_NUM];
  logic [FW-1:0] s1_sa_r;
  logic [FW-1:0] s1_wd_r;
  logic [7:0]    s1_dc_r [CH_NUM];
  logic [7:0]    s1_dal_r;
  logic          s1_byp_r;

  logic [FW-1:0] oa_nxt;
  logic          s2_v_r;
  logic [PW-1:0] s2_ps_r [CH_NUM];
  logic [PW-1:0] s2_pd_r [CH_NUM];
  logic [FW-1:0] s2_oa_r;
  logic [7:0]    s2_dc_r [CH_NUM];
  logic [7:0]    s2_dal_r;
  logic          s2_byp_r;

  logic [FW+7:0] alpha_wide;
  logic [8:0]    alpha_q;
  logic          s3_v_r;
  logic [PW-1:0] s3_num_r [CH_NUM];
  logic [FW-1:0] s3_oa_r;
  logic [7:0]    s3_alpha_r;
  logic [7:0]    s3_dc_r [CH_NUM];
  logic [7:0]    s3_dal_r;
  logic          s3_byp_r;

  logic                dv_v_r     [QUO_BITS+1];
  logic [RW-1:0]       dv_rem_r   [QUO_BITS+1][CH_NUM];
  logic [QUO_BITS-1:0] dv_q_r     [QUO_BITS+1][CH_NUM];
  logic [FW-1:0]       dv_oa_r    [QUO_BITS+1];
  logic [7:0]          dv_alpha_r [QUO_BITS+1];
  logic [7:0]          dv_dc_r    [QUO_BITS+1][CH_NUM];
  logic [7:0]          dv_dal_r   [QUO_BITS+1];
  logic                dv_byp_r   [QUO_BITS+1];

  logic [RW-1:0]       rem_nxt [QUO_BITS+1][CH_NUM];
  logic [QUO_BITS-1:0] q_nxt   [QUO_BITS+1][CH_NUM];

  logic       out_v_r;
  logic [7:0] out_c_r [CH_NUM];
  logic [7:0] out_a_r;
  logic [7:0] ch_res  [CH_NUM];

  assign adv     = !out_v_r || out_ch.ready;
  assign q_ready = adv;

  assign in_sc[0] = q_item.src_red;
  assign in_sc[1] = q_item.src_green;
  assign in_sc[2] = q_item.src_blue;
  assign in_dc[0] = q_item.dst_red;
  assign in_dc[1] = q_item.dst_green;
  assign in_dc[2] = q_item.dst_blue;

  assign wd_prod    = PW'(s0_da_r) * PW'(s0_inv_r);
  assign oa_nxt     = s1_sa_r + s1_wd_r;
  assign alpha_wide = {s2_oa_r, 8'd0} - (FW + 8)'(s2_oa_r);
  assign alpha_q    = alpha_wide[FW+7:FracBits];

  always_comb begin
    logic [RW-1:0] dsh;
    logic          ge;
    dsh = '0;
    ge  = 1'b0;
    for (int c = 0; c < CH_NUM; c++) begin
      rem_nxt[0][c] = {s3_num_r[c], 8'd0} - RW'(s3_num_r[c]);
      q_nxt[0][c]   = '0;
    end
    for (int j = 1; j <= QUO_BITS; j++) begin
      for (int c = 0; c < CH_NUM; c++) begin
        dsh           = RW'(dv_oa_r[j-1]) << (FracBits + QUO_BITS - j);
        ge            = (dv_rem_r[j-1][c] >= dsh);
        rem_nxt[j][c] = ge ? (dv_rem_r[j-1][c] - dsh) : dv_rem_r[j-1][c];
        q_nxt[j][c]   = dv_q_r[j-1][c] | (QUO_BITS'(ge) << (QUO_BITS - j));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CH_NUM; c++) begin
      if (dv_byp_r[QUO_BITS]) begin
        ch_res[c] = dv_dc_r[QUO_BITS][c];
      end else if (dv_q_r[QUO_BITS][c][QUO_BITS-1]) begin
        ch_res[c] = PIX_MAX;
      end else begin
        ch_res[c] = dv_q_r[QUO_BITS][c][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int j = 0; j <= QUO_BITS; j++) begin
        dv_v_r[j] <= 1'b0;
      end
    end else if (adv) begin
      s0_v_r    <= q_valid;
      s1_v_r    <= s0_v_r;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      dv_v_r[0] <= s3_v_r;
      for (int j = 1; j <= QUO_BITS; j++) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
      out_v_r <= dv_v_r[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < CH_NUM; c++) begin
        s0_fs_r[c] <= frac_lut[in_sc[c]];
        s0_fd_r[c] <= frac_lut[in_dc[c]];
        s0_dc_r[c] <= in_dc[c];
        s1_fs_r[c] <= s0_fs_r[c];
        s1_fd_r[c] <= s0_fd_r[c];
        s1_dc_r[c] <= s0_dc_r[c];
        s2_ps_r[c] <= PW'(s1_fs_r[c]) * PW'(s1_sa_r);
        s2_pd_r[c] <= PW'(s1_fd_r[c]) * PW'(s1_wd_r);
        s2_dc_r[c] <= s1_dc_r[c];
        s3_num_r[c] <= s2_ps_r[c] + s2_pd_r[c];
        s3_dc_r[c]  <= s2_dc_r[c];
        out_c_r[c]  <= ch_res[c];
      end
      s0_sa_r  <= frac_lut[q_item.src_coverage];
      s0_da_r  <= frac_lut[q_item.dst_alpha];
      s0_inv_r <= ONE - frac_lut[q_item.src_coverage];
      s0_dal_r <= q_item.dst_alpha;
      s0_byp_r <= q_item.bypass;

      s1_sa_r  <= s0_sa_r;
      s1_wd_r  <= wd_prod[FracBits +: FW];
      s1_dal_r <= s0_dal_r;
      s1_byp_r <= s0_byp_r;

      s2_oa_r  <= oa_nxt;
      s2_dal_r <= s1_dal_r;
      s2_byp_r <= s1_byp_r || (oa_nxt == '0);

      s3_oa_r    <= s2_oa_r;
      s3_alpha_r <= alpha_q[8] ? PIX_MAX : alpha_q[7:0];
      s3_dal_r   <= s2_dal_r;
      s3_byp_r   <= s2_byp_r;

      dv_oa_r[0]    <= s3_oa_r;
      dv_alpha_r[0] <= s3_alpha_r;
      dv_dal_r[0]   <= s3_dal_r;
      dv_byp_r[0]   <= s3_byp_r;
      for (int c = 0; c < CH_NUM; c++) begin
        dv_rem_r[0][c] <= rem_nxt[0][c];
        dv_q_r[0][c]   <= q_nxt[0][c];
        dv_dc_r[0][c]  <= s3_dc_r[c];
      end
      for (int j = 1; j <= QUO_BITS; j++) begin
        dv_oa_r[j]    <= dv_oa_r[j-1];
        dv_alpha_r[j] <= dv_alpha_r[j-1];
        dv_dal_r[j]   <= dv_dal_r[j-1];
        dv_byp_r[j]   <= dv_byp_r[j-1];
        for (int c = 0; c < CH_NUM; c++) begin
          dv_rem_r[j][c] <= rem_nxt[j][c];
          dv_q_r[j][c]   <= q_nxt[j][c];
          dv_dc_r[j][c]  <= dv_dc_r[j-1][c];
        end
      end

      out_a_r <= dv_byp_r[QUO_BITS] ? dv_dal_r[QUO_BITS] : dv_alpha_r[QUO_BITS];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_red   = out_c_r[0];
  assign out_ch.out_green = out_c_r[1];
  assign out_ch.out_blue  = out_c_r[2];
  assign out_ch.out_alpha = out_a_r;

endmodule

// ===== design/straight_alpha_over_blend.sv =====
// Top level of the straight-alpha source-over pixel blend block.
//
//   Channel   Direction  Payload
//   in_ch     sink       source RGB, coverage, destination RGBA
//   out_ch    source     blended RGBA
//
// One pixel is accepted per cycle sustained while the output is not stalled.
// The multipliers are followed by a restoring quotient pipeline that resolves nine quotient bits per channel.
// Reset is synchronous on rst_n and clears all valid flags and queue pointers.
// A stalled output freezes the blend pipeline; the four-entry queue keeps taking requests
// until it is full, and only then does in_ch.ready drop.
module straight_alpha_over_blend #(
  parameter int FRAC_BITS = svb_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  svb_in_if.sink     in_ch,
  svb_out_if.source  out_ch
);
  import svb_pkg::*;

  logic   fr_valid;
  item_t  fr_item;
  logic   fr_ready;
  logic   q_valid;
  item_t  q_item;
  logic   q_ready;
  qstat_t q_stat;

  svb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (fr_valid),
    .push_item  (fr_item),
    .push_ready (fr_ready)
  );

  svb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_item  (fr_item),
    .push_ready (fr_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready),
    .stat       (q_stat)
  );

  svb_back #(
    .FracBits (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (fr_valid && q_stat.full))
    else $error("input stalled while the queue had room");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_stat.empty)
    else $error("queue reports full and empty at once");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_valid && fr_ready && !(q_valid && q_ready)) |=> !q_stat.empty)
    else $error("request pushed into the queue was lost");

endmodule
